[rtl/sdpd_pkg.sv]
// Package: shared constants, queue entry type and button remap table for the 6DOF decoder.
`timescale 1ns / 1ps
package sdpd_pkg;

  localparam int STORE_DEPTH_DEF = 64;

  // only the first bytes of a packet are ever decoded
  localparam int PKT_REGS = 16;
  localparam int PKT_AW   = 4;

  localparam int MOTION_LEN = 16;
  localparam int BUTTON_LEN = 4;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_ESC_CR = 8'h4D;
  localparam logic [7:0] CH_MOTION = 8'h44;
  localparam logic [7:0] CH_BUTTON = 8'h4B;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  localparam int MASK_W = 27;
  localparam int BTN_BITS = 8;

  typedef logic [4:0] mask_pos_t [15];
  localparam mask_pos_t MASK_POS = '{5'd12, 5'd13, 5'd14, 5'd15, 5'd22, 5'd25, 5'd23, 5'd24,
                                     5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd8, 5'd26};

  // one classified byte on its way to the packet builder
  typedef struct packed {
    logic       store;
    logic [7:0] data;
    logic       eop;
  } op_t;

endpackage

[rtl/sdpd_front.sv]
// Front end: caret unescaping and end-of-packet detection per received byte.
`timescale 1ns / 1ps
module sdpd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             q_valid,
  input  logic             q_ready,
  output sdpd_pkg::op_t    q_op
);

  logic esc_r, esc_nxt;
  logic accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_op.store = 1'b0;
    q_op.data  = in_rx_byte;
    q_op.eop   = (in_rx_byte == sdpd_pkg::CH_CR);
    esc_nxt    = esc_r;
    if (esc_r) begin
      // escaped M stands for a stored CR; escaped caret for a caret; anything else is not stored
      if (in_rx_byte == sdpd_pkg::CH_ESC_CR) begin
        q_op.store = 1'b1;
        q_op.data  = sdpd_pkg::CH_CR;
      end else if (in_rx_byte == sdpd_pkg::CH_CARET) begin
        q_op.store = 1'b1;
      end
      esc_nxt = 1'b0;
    end else if (in_rx_byte == sdpd_pkg::CH_CARET) begin
      esc_nxt = 1'b1;
    end else begin
      q_op.store = 1'b1;
    end
  end

  // bytes that neither store nor end a packet never enter the queue
  assign q_valid = in_valid && (q_op.store || q_op.eop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else if (accept) begin
      esc_r <= esc_nxt;
    end
  end

endmodule

[rtl/sdpd_fifo.sv]
// Two-entry queue between front end and packet builder.
`timescale 1ns / 1ps
module sdpd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sdpd_pkg::op_t  in_op,
  output logic           out_valid,
  input  logic           out_ready,
  output sdpd_pkg::op_t  out_op
);

  sdpd_pkg::op_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_op    = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_op;
    end
  end

endmodule

[rtl/sdpd_back.sv]
// Packet builder: write index, packet byte registers and result decode.
`timescale 1ns / 1ps
module sdpd_back #(
  parameter int STORE_DEPTH = sdpd_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  sdpd_pkg::op_t       q_op,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_packet_kind,
  output logic signed [15:0]  out_trans_x,
  output logic signed [15:0]  out_trans_y,
  output logic signed [15:0]  out_trans_z,
  output logic signed [15:0]  out_rot_x,
  output logic signed [15:0]  out_rot_y,
  output logic signed [15:0]  out_rot_z,
  output logic [26:0]         out_button_mask
);

  localparam int IDX_W = $clog2(STORE_DEPTH);

  // store positions past the decoded window are never read, so only these are kept
  logic [7:0]       pkt_r [sdpd_pkg::PKT_REGS];
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_inc, idx_wr;
  logic             accept, hit_motion, hit_button, hit;
  logic [15:0]      val [6];
  logic [sdpd_pkg::BTN_BITS-1:0] btn;
  logic [sdpd_pkg::MASK_W-1:0]   mask;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r;
  logic [15:0] tx_r, ty_r, tz_r, rx_r, ry_r, rz_r;
  logic [sdpd_pkg::MASK_W-1:0] mask_r;

  assign q_ready = !out_valid_r || out_ready;
  assign accept  = q_valid && q_ready;

  always_comb begin
    idx_inc = (idx_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : idx_r + IDX_W'(1);
    idx_wr  = q_op.store ? idx_inc : idx_r;
    idx_nxt = idx_r;
    if (accept) begin
      idx_nxt = q_op.eop ? '0 : idx_wr;
    end
  end

  // length check uses the index after this beat's write; the bytes decoded
  // never include the one written in the same beat
  assign hit_motion = q_op.eop && (pkt_r[0] == sdpd_pkg::CH_MOTION) &&
                      (int'(idx_wr) == sdpd_pkg::MOTION_LEN);
  assign hit_button = q_op.eop && (pkt_r[0] == sdpd_pkg::CH_BUTTON) &&
                      (int'(idx_wr) == sdpd_pkg::BUTTON_LEN);
  assign hit = hit_motion || hit_button;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      val[i] = {pkt_r[3 + 2 * i], pkt_r[4 + 2 * i]};
    end
  end

  assign btn = {pkt_r[1][3:0] & sdpd_pkg::NIBBLE_MASK[3:0],
                pkt_r[2][3:0] & sdpd_pkg::NIBBLE_MASK[3:0]};

  always_comb begin
    mask = '0;
    for (int k = 0; k < sdpd_pkg::BTN_BITS; k++) begin
      if (btn[k]) begin
        mask[sdpd_pkg::MASK_POS[k]] = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && q_op.store && (int'(idx_r) < sdpd_pkg::PKT_REGS)) begin
      pkt_r[idx_r[sdpd_pkg::PKT_AW-1:0]] <= q_op.data;
    end
    if (accept && hit) begin
      kind_r <= hit_button ? sdpd_pkg::KIND_BUTTON : sdpd_pkg::KIND_MOTION;
      tx_r   <= hit_motion ? val[0] : 16'd0;
      ty_r   <= hit_motion ? 16'(-val[2]) : 16'd0;
      tz_r   <= hit_motion ? 16'(-val[1]) : 16'd0;
      rx_r   <= hit_motion ? val[3] : 16'd0;
      ry_r   <= hit_motion ? 16'(-val[5]) : 16'd0;
      rz_r   <= hit_motion ? 16'(-val[4]) : 16'd0;
      mask_r <= hit_button ? mask : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packet_kind = kind_r;
  assign out_trans_x     = $signed(tx_r);
  assign out_trans_y     = $signed(ty_r);
  assign out_trans_z     = $signed(tz_r);
  assign out_rot_x       = $signed(rx_r);
  assign out_rot_y       = $signed(ry_r);
  assign out_rot_z       = $signed(rz_r);
  assign out_button_mask = mask_r;

endmodule

[rtl/sixdof_serial_packet_decoder_top.sv]
// Top level: six-axis serial packet decoder.
//
//  channel | ports                                  | beat
//  --------+----------------------------------------+-----------------------------
//  in      | in_valid/in_ready, in_rx_byte          | one received serial byte
//  out     | out_valid/out_ready, out_packet_kind,  | one decoded motion or button
//          | out_trans_*, out_rot_*, out_button_mask| packet
//
// One byte per cycle sustained while the queue has room; the packet builder takes one queued byte
// per cycle unless a result is still held. The closing CR passes through a queue entry, then sets the
// builder's registered out_valid; each byte queued ahead of it delays the result further.
// Reset clears the escape flag, write index, queue and output valid; packet bytes are not cleared.
// A stalled output holds the builder, the two-entry queue absorbs up to two more queued bytes,
// then in_ready drops.
`timescale 1ns / 1ps
module sixdof_serial_packet_decoder_top #(
  parameter int STORE_DEPTH = sdpd_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_packet_kind,
  output logic signed [15:0]  out_trans_x,
  output logic signed [15:0]  out_trans_y,
  output logic signed [15:0]  out_trans_z,
  output logic signed [15:0]  out_rot_x,
  output logic signed [15:0]  out_rot_y,
  output logic signed [15:0]  out_rot_z,
  output logic [26:0]         out_button_mask
);

  logic          fq_valid, fq_ready;
  sdpd_pkg::op_t fq_op;
  logic          qb_valid, qb_ready;
  sdpd_pkg::op_t qb_op;

  sdpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_op       (fq_op)
  );

  sdpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_op     (fq_op),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_op    (qb_op)
  );

  sdpd_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (qb_valid),
    .q_ready         (qb_ready),
    .q_op            (qb_op),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packet_kind (out_packet_kind),
    .out_trans_x     (out_trans_x),
    .out_trans_y     (out_trans_y),
    .out_trans_z     (out_trans_z),
    .out_rot_x       (out_rot_x),
    .out_rot_y       (out_rot_y),
    .out_rot_z       (out_rot_z),
    .out_button_mask (out_button_mask)
  );

endmodule
